>>> rtl/core/jst_pkg.sv
package jst_pkg;

    localparam int JOB_ID_BITS = 16;
    localparam int STATE_BITS  = 2;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

    typedef logic [2:0]             t_op;
    typedef logic [1:0]             t_status;
    typedef logic [JOB_ID_BITS-1:0] t_job_id;
    typedef logic [STATE_BITS-1:0]  t_run_state;
    typedef logic [CNT_BITS-1:0]    t_count;

    localparam t_op OP_ADD      = 3'd0;
    localparam t_op OP_DELETE   = 3'd1;
    localparam t_op OP_FIND_PID = 3'd2;
    localparam t_op OP_FIND_JID = 3'd3;
    localparam t_op OP_SET_PID  = 3'd4;
    localparam t_op OP_SET_JID  = 3'd5;
    localparam t_op OP_FIND_FG  = 3'd6;
    localparam t_op OP_LIST     = 3'd7;

    localparam t_status STAT_OK       = 2'd0;
    localparam t_status STAT_NOTFOUND = 2'd1;
    localparam t_status STAT_FULL     = 2'd2;
    localparam t_status STAT_BADKEY   = 2'd3;

    localparam t_run_state RS_FG = 2'd1;

    localparam t_job_id ID_MAX = 16'hFFFF;

endpackage

>>> rtl/core/job_slot_table_unit.sv
// a zero key is answered in the cycle after start; other commands scan the
// slot memory one entry per cycle, delete always scans every slot and list returns
// one word per live slot, at most MAX_RESULTS words
// throughput: one command at a time, busy stays high for the whole scan
// reset: synchronous, clears all slots to empty and sets the job id counter to 1
// results are a one-cycle strobe and the receiver cannot stall
module job_slot_table_unit #(
    parameter int NUM_SLOTS    = 16,
    parameter int PROC_ID_BITS = 22
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  jst_pkg::t_op                 i_op,
    input  logic [PROC_ID_BITS-1:0]      i_proc_id,
    input  jst_pkg::t_job_id             i_job_id,
    input  jst_pkg::t_run_state          i_new_state,
    output logic                         o_valid,
    output jst_pkg::t_status             o_status,
    output logic [PROC_ID_BITS-1:0]      o_out_proc_id,
    output jst_pkg::t_job_id             o_out_job_id,
    output jst_pkg::t_run_state          o_out_state,
    output logic                         o_last
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int JB = jst_pkg::JOB_ID_BITS;
    localparam int SB = jst_pkg::STATE_BITS;
    localparam int DW = PROC_ID_BITS + JB + SB;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [DW-1:0]             r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]      r_live, n_live;

    logic [1:0]                r_state, n_state;
    jst_pkg::t_op              r_op, n_op;
    logic [PROC_ID_BITS-1:0]   r_pid, n_pid;
    jst_pkg::t_job_id          r_jid, n_jid;
    jst_pkg::t_run_state       r_ns, n_ns;
    logic [CW-1:0]             r_idx, n_idx;
    logic                      r_rd_vld, n_rd_vld;
    logic [IW-1:0]             r_rd_idx;
    logic                      r_rd_live;
    logic [DW-1:0]             r_rd_data;
    jst_pkg::t_job_id          r_next_id, n_next_id;
    logic                      r_hit, n_hit;
    jst_pkg::t_job_id          r_max, n_max;
    logic                      r_pend, n_pend;
    logic [DW-1:0]             r_pend_data, n_pend_data;
    jst_pkg::t_count           r_cnt, n_cnt;

    logic                      r_valid, n_valid;
    jst_pkg::t_status          r_status, n_status;
    logic [PROC_ID_BITS-1:0]   r_opid, n_opid;
    jst_pkg::t_job_id          r_ojid, n_ojid;
    jst_pkg::t_run_state       r_ost, n_ost;
    logic                      r_last, n_last;

    logic                      w_en;
    logic [IW-1:0]             w_addr;
    logic [DW-1:0]             w_data;

    logic [PROC_ID_BITS-1:0]   rd_proc;
    jst_pkg::t_job_id          rd_job;
    jst_pkg::t_run_state       rd_st;
    logic                      match;
    logic                      first_del;
    logic                      list_full;
    logic                      stop;
    logic                      issue;
    logic                      is_last;
    logic                      bad_key;
    jst_pkg::t_job_id          max_in;
    jst_pkg::t_job_id          add_id;

    assign rd_proc = r_rd_data[DW-1 -: PROC_ID_BITS];
    assign rd_job  = r_rd_data[SB +: JB];
    assign rd_st   = r_rd_data[SB-1:0];

    // shared compare against the scanned slot
    always_comb begin
        case (r_op)
            jst_pkg::OP_ADD:      match = !r_rd_live;
            jst_pkg::OP_DELETE,
            jst_pkg::OP_FIND_PID,
            jst_pkg::OP_SET_PID:  match = r_rd_live && (rd_proc == r_pid);
            jst_pkg::OP_FIND_JID,
            jst_pkg::OP_SET_JID:  match = r_rd_live && (rd_job == r_jid);
            jst_pkg::OP_FIND_FG:  match = r_rd_live && (rd_st == jst_pkg::RS_FG);
            default:              match = r_rd_live;
        endcase
    end

    assign first_del = (r_op == jst_pkg::OP_DELETE) && match && !r_hit;
    assign max_in    = (r_rd_live && !first_del && (rd_job > r_max)) ? rd_job : r_max;
    assign list_full = (r_op == jst_pkg::OP_LIST) && match
                       && ((r_cnt + jst_pkg::t_count'(1))
                           == jst_pkg::t_count'(jst_pkg::MAX_RESULTS));
    assign stop      = (r_state == S_SCAN) && r_rd_vld
                       && (list_full
                           || (match && (r_op != jst_pkg::OP_DELETE)
                               && (r_op != jst_pkg::OP_LIST)));
    assign issue     = (r_state == S_SCAN) && (r_idx < CW'(NUM_SLOTS)) && !stop;
    assign is_last   = (r_rd_idx == IW'(NUM_SLOTS - 1));

    always_comb begin
        case (i_op)
            jst_pkg::OP_ADD,
            jst_pkg::OP_DELETE,
            jst_pkg::OP_FIND_PID,
            jst_pkg::OP_SET_PID:  bad_key = (i_proc_id == '0);
            jst_pkg::OP_FIND_JID,
            jst_pkg::OP_SET_JID:  bad_key = (i_job_id == '0);
            default:              bad_key = 1'b0;
        endcase
    end

    // id counter step after an add
    always_comb begin
        add_id = (r_next_id < jst_pkg::ID_MAX) ? r_next_id + 16'd1 : r_next_id;
        if (add_id > jst_pkg::t_job_id'(NUM_SLOTS)) begin
            add_id = 16'd1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pid       = r_pid;
        n_jid       = r_jid;
        n_ns        = r_ns;
        n_live      = r_live;
        n_next_id   = r_next_id;
        n_hit       = r_hit;
        n_max       = r_max;
        n_pend      = r_pend;
        n_pend_data = r_pend_data;
        n_cnt       = r_cnt;
        n_rd_vld    = issue;
        n_idx       = issue ? r_idx + CW'(1) : r_idx;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_opid      = r_opid;
        n_ojid      = r_ojid;
        n_ost       = r_ost;
        n_last      = r_last;
        w_en        = 1'b0;
        w_addr      = r_rd_idx;
        w_data      = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_op;
                    n_pid = i_proc_id;
                    n_jid = i_job_id;
                    n_ns  = i_new_state;
                    if (bad_key) begin
                        n_valid  = 1'b1;
                        n_status = jst_pkg::STAT_BADKEY;
                        n_opid   = '0;
                        n_ojid   = '0;
                        n_ost    = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_hit   = 1'b0;
                        n_max   = '0;
                        n_pend  = 1'b0;
                        n_cnt   = '0;
                    end
                end
            end
            S_SCAN: begin
                if (r_rd_vld) begin
                    case (r_op)
                        jst_pkg::OP_ADD: begin
                            if (match) begin
                                w_en             = 1'b1;
                                w_data           = {r_pid, r_next_id, r_ns};
                                n_live[r_rd_idx] = 1'b1;
                                n_next_id        = add_id;
                                n_valid          = 1'b1;
                                n_status         = jst_pkg::STAT_OK;
                                n_opid           = r_pid;
                                n_ojid           = r_next_id;
                                n_ost            = r_ns;
                                n_last           = 1'b1;
                                n_state          = S_IDLE;
                            end else if (is_last) begin
                                n_valid  = 1'b1;
                                n_status = jst_pkg::STAT_FULL;
                                n_opid   = '0;
                                n_ojid   = '0;
                                n_ost    = '0;
                                n_last   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                        jst_pkg::OP_DELETE: begin
                            n_max = max_in;
                            if (first_del) begin
                                n_hit            = 1'b1;
                                n_live[r_rd_idx] = 1'b0;
                                n_valid          = 1'b1;
                                n_status         = jst_pkg::STAT_OK;
                                n_opid           = rd_proc;
                                n_ojid           = rd_job;
                                n_ost            = rd_st;
                                n_last           = 1'b1;
                            end
                            if (is_last) begin
                                n_state = S_IDLE;
                                if (r_hit || first_del) begin
                                    n_next_id = (max_in == jst_pkg::ID_MAX) ? jst_pkg::ID_MAX
                                                                           : max_in + 16'd1;
                                end else begin
                                    n_valid  = 1'b1;
                                    n_status = jst_pkg::STAT_NOTFOUND;
                                    n_opid   = '0;
                                    n_ojid   = '0;
                                    n_ost    = '0;
                                    n_last   = 1'b1;
                                end
                            end
                        end
                        jst_pkg::OP_LIST: begin
                            if (match) begin
                                if (r_pend) begin
                                    n_valid  = 1'b1;
                                    n_status = jst_pkg::STAT_OK;
                                    n_opid   = r_pend_data[DW-1 -: PROC_ID_BITS];
                                    n_ojid   = r_pend_data[SB +: JB];
                                    n_ost    = r_pend_data[SB-1:0];
                                    n_last   = 1'b0;
                                end
                                n_pend      = 1'b1;
                                n_pend_data = r_rd_data;
                                n_cnt       = r_cnt + jst_pkg::t_count'(1);
                            end
                            if (list_full || is_last) begin
                                n_state = S_FLUSH;
                            end
                        end
                        default: begin
                            if (match) begin
                                if ((r_op == jst_pkg::OP_SET_PID)
                                        || (r_op == jst_pkg::OP_SET_JID)) begin
                                    w_en   = 1'b1;
                                    w_data = {rd_proc, rd_job, r_ns};
                                    n_ost  = r_ns;
                                end else begin
                                    n_ost  = rd_st;
                                end
                                n_valid  = 1'b1;
                                n_status = jst_pkg::STAT_OK;
                                n_opid   = rd_proc;
                                n_ojid   = rd_job;
                                n_last   = 1'b1;
                                n_state  = S_IDLE;
                            end else if (is_last) begin
                                n_valid  = 1'b1;
                                n_status = jst_pkg::STAT_NOTFOUND;
                                n_opid   = '0;
                                n_ojid   = '0;
                                n_ost    = '0;
                                n_last   = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_FLUSH: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_state = S_IDLE;
                if (r_pend) begin
                    n_status = jst_pkg::STAT_OK;
                    n_opid   = r_pend_data[DW-1 -: PROC_ID_BITS];
                    n_ojid   = r_pend_data[SB +: JB];
                    n_ost    = r_pend_data[SB-1:0];
                end else begin
                    n_status = jst_pkg::STAT_NOTFOUND;
                    n_opid   = '0;
                    n_ojid   = '0;
                    n_ost    = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot memory, at most one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[r_idx[IW-1:0]];
        r_rd_live <= r_live[r_idx[IW-1:0]];
        r_rd_idx  <= r_idx[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_live    <= '0;
            r_next_id <= 16'd1;
            r_rd_vld  <= 1'b0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_pend    <= 1'b0;
            r_cnt     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_next_id <= n_next_id;
            r_rd_vld  <= n_rd_vld;
            r_idx     <= n_idx;
            r_hit     <= n_hit;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pid       <= n_pid;
        r_jid       <= n_jid;
        r_ns        <= n_ns;
        r_max       <= n_max;
        r_pend_data <= n_pend_data;
        r_status    <= n_status;
        r_opid      <= n_opid;
        r_ojid      <= n_ojid;
        r_ost       <= n_ost;
        r_last      <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_proc_id = r_opid;
    assign o_out_job_id  = r_ojid;
    assign o_out_state   = r_ost;
    assign o_last        = r_last;

endmodule
